>>> rtl/core/csv_row_field_splitter_unit_defines.svh
// assertion macros for the csv row/field splitter checker
// needs clk and rst_n in scope where a macro is used
`ifndef CSV_ROW_FIELD_SPLITTER_UNIT_DEFINES_SVH
`define CSV_ROW_FIELD_SPLITTER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CSVS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csvs check failed");

// next-cycle implication, disabled while in reset
`define CSVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csvs check failed");

`endif

>>> rtl/core/csvs_pkg.sv
// types and constants for the csv row/field splitter
// no dependencies
`timescale 1ns / 1ps

package csvs_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } kind_t;

  // parser flags carried from one byte to the next
  typedef struct packed {
    logic in_quotes;
    logic field_is_empty;
    logic quote_pending;
    logic cr_pending;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    in_quotes: 1'b0, field_is_empty: 1'b1, quote_pending: 1'b0, cr_pending: 1'b0
  };

  typedef struct packed {
    kind_t      kind;
    logic [7:0] text_byte;
    logic       last;
  } result_t;

  // everything one input transaction produces
  typedef struct packed {
    logic [1:0]   num_results;
    result_t      res0;
    result_t      res1;
    parse_state_t next_state;
  } decode_t;

endpackage

>>> rtl/core/csvs_decode.sv
// combinational byte decoder: flags + one input byte -> up to two results
// depends on csvs_pkg
`timescale 1ns / 1ps

module csvs_decode (
  input  csvs_pkg::parse_state_t state,
  input  logic [7:0]             in_byte,
  input  logic                   end_of_input,
  output csvs_pkg::decode_t      dec
);
  import csvs_pkg::*;

  parse_state_t ns;
  result_t      r0;
  result_t      r1;
  logic [1:0]   n;
  logic         done;
  logic         em_valid [2];
  result_t      em       [2];

  always_comb begin
    ns          = state;
    done        = 1'b0;
    em_valid[0] = 1'b0;
    em_valid[1] = 1'b0;
    em[0]       = '{kind: KIND_TEXT, text_byte: 8'h00, last: 1'b0};
    em[1]       = '{kind: KIND_TEXT, text_byte: 8'h00, last: 1'b0};

    // resolve the one-byte lookahead first
    if (state.cr_pending) begin
      ns.cr_pending = 1'b0;
      if (!end_of_input && in_byte == CH_LF) begin
        em_valid[0] = 1'b1;
        em[0].kind  = KIND_ROW;
        ns          = PARSE_RESET;
        done        = 1'b1;
      end else begin
        em_valid[0]       = 1'b1;
        em[0].text_byte   = CH_CR;
        ns.field_is_empty = 1'b0;
      end
    end else if (state.quote_pending) begin
      ns.quote_pending = 1'b0;
      if (!end_of_input && in_byte == CH_QUOTE) begin
        em_valid[0]       = 1'b1;
        em[0].text_byte   = CH_QUOTE;
        ns.field_is_empty = 1'b0;
        done              = 1'b1;
      end else if (ns.in_quotes) begin
        ns.in_quotes = 1'b0;
      end else begin
        em_valid[0]       = 1'b1;
        em[0].text_byte   = CH_QUOTE;
        ns.field_is_empty = 1'b0;
      end
    end

    // the byte itself, in slot 1 after any flushed byte
    if (!done) begin
      priority if (end_of_input) begin
        em_valid[1] = 1'b1;
        em[1].kind  = KIND_ROW;
        ns          = PARSE_RESET;
      end else if (in_byte == CH_LF && !ns.in_quotes) begin
        em_valid[1] = 1'b1;
        em[1].kind  = KIND_ROW;
        ns          = PARSE_RESET;
      end else if (in_byte == CH_CR && !ns.in_quotes) begin
        ns.cr_pending = 1'b1;
      end else if (in_byte == CH_QUOTE && ns.field_is_empty && !ns.in_quotes) begin
        ns.in_quotes = 1'b1;
      end else if (in_byte == CH_QUOTE) begin
        ns.quote_pending = 1'b1;
      end else if (in_byte == CH_COMMA && !ns.in_quotes) begin
        em_valid[1]       = 1'b1;
        em[1].kind        = KIND_FIELD;
        ns.field_is_empty = 1'b1;
      end else begin
        em_valid[1]       = 1'b1;
        em[1].text_byte   = in_byte;
        ns.field_is_empty = 1'b0;
      end
    end

    // pack the emitted slots to the front and flag the final one
    n  = {1'b0, em_valid[0]} + {1'b0, em_valid[1]};
    r0 = em_valid[0] ? em[0] : em[1];
    r1 = em[1];
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  assign dec = '{num_results: n, res0: r0, res1: r1, next_state: ns};

endmodule

>>> rtl/core/csv_row_field_splitter_unit.sv
// top level of the csv row/field splitter: input handshake, parser flags,
// result queue; depends on csvs_pkg and csvs_decode
`timescale 1ns / 1ps

// csv row/field splitter. One csv byte (or an end-of-input mark) is taken per
// input transaction and turned into zero, one or two result transactions:
// field text bytes, field-end marks and row-end marks, with last set on the
// final result of each input. Quoting follows the usual csv rules: a quote at
// the start of an empty field opens quoting, a doubled quote is a literal
// quote, comma/LF/CRLF split only outside quotes, stray quotes and CRs stay
// text, and end of input always closes a row. The decode is a single short
// combinational pass from the input ports and four registered parser flags
// into a three-entry result queue, so an input byte is taken every cycle as
// long as the queue holds at most one result. Sustained rate is one input per
// cycle while out_ready stays high, for inputs that yield one result or none;
// for an input that yields two results the output port (one result per cycle)
// sets the rate then. Results reach the output port from the queue registers.
// in_ready does not depend on out_ready in the same cycle.
module csv_row_field_splitter_unit (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_text_byte,
  output logic       out_last
);
  import csvs_pkg::*;

  localparam int QDEPTH = 3;

  parse_state_t state_r;
  parse_state_t state_nxt;
  decode_t      dec;

  result_t      q_r   [QDEPTH];
  result_t      q_nxt [QDEPTH];
  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;
  logic [1:0]   base;

  logic         push;
  logic         pop;

  csvs_decode u_decode (
    .state        (state_r),
    .in_byte      (in_byte),
    .end_of_input (in_end_of_input),
    .dec          (dec)
  );

  // room for two results even if nothing drains this cycle
  assign in_ready  = (cnt_r <= 2'd1);
  assign push      = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;

  assign out_kind      = q_r[0].kind;
  assign out_text_byte = q_r[0].text_byte;
  assign out_last      = q_r[0].last;

  // parser flags only move on an accepted transaction
  assign state_nxt = push ? dec.next_state : state_r;

  // queue: head at entry 0, shift on pop, append behind the survivors
  always_comb begin
    base    = cnt_r - {1'b0, pop};
    cnt_nxt = base + (push ? dec.num_results : 2'd0);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push && dec.num_results != 2'd0 && base == 2'(i)) begin
        q_nxt[i] = dec.res0;
      end
      if (push && dec.num_results == 2'd2 && base + 2'd1 == 2'(i)) begin
        q_nxt[i] = dec.res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PARSE_RESET;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // payload entries need no reset, the count guards them
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

>>> rtl/core/csvs_checker.sv
// port-level checks for csv_row_field_splitter_unit, attached by bind
// depends on csvs_pkg and csv_row_field_splitter_unit_defines.svh
`timescale 1ns / 1ps
`include "csv_row_field_splitter_unit_defines.svh"

module csvs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_end_of_input,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_text_byte,
  input logic       out_last
);
  import csvs_pkg::*;

  // a stalled result stays on the port
  `CSVS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_text_byte) && $stable(out_last))
  // marks carry no text
  `CSVS_ASSERT_SAME(a_mark_zero, out_valid && out_kind != KIND_TEXT, out_text_byte == 8'h00)
  // a row end is always the final result of its transaction
  `CSVS_ASSERT_SAME(a_row_last, out_valid && out_kind == KIND_ROW, out_last)
  // end of input always yields a result right after acceptance
  `CSVS_ASSERT_NEXT(a_eoi_result, in_valid && in_ready && in_end_of_input, out_valid)

endmodule

bind csv_row_field_splitter_unit csvs_checker u_csvs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_end_of_input (in_end_of_input),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_text_byte   (out_text_byte),
  .out_last        (out_last)
);
